// ----- design/rcse_pkg.sv -----
// Shared types and constants for the register CPU step executor.
`default_nettype none
package rcse_pkg;

	localparam int ADDR_BITS_DEF = 16;

	// opcodes
	localparam logic [3:0] OP_JMP  = 4'd0;
	localparam logic [3:0] OP_MOVI = 4'd1;
	localparam logic [3:0] OP_MOV  = 4'd2;
	localparam logic [3:0] OP_LDA  = 4'd3;
	localparam logic [3:0] OP_STO  = 4'd4;
	localparam logic [3:0] OP_SHL  = 4'd5;
	localparam logic [3:0] OP_SHR  = 4'd6;
	localparam logic [3:0] OP_NOT  = 4'd7;
	localparam logic [3:0] OP_AND  = 4'd8;
	localparam logic [3:0] OP_OR   = 4'd9;
	localparam logic [3:0] OP_XOR  = 4'd10;
	localparam logic [3:0] OP_ADD  = 4'd11;
	localparam logic [3:0] OP_MUL  = 4'd12;
	localparam logic [3:0] OP_DIV  = 4'd13;
	localparam logic [3:0] OP_MOD  = 4'd14;
	localparam logic [3:0] OP_BAD  = 4'd15;

	// register read selects
	localparam logic [1:0] RSEL_A = 2'd0;
	localparam logic [1:0] RSEL_B = 2'd1;
	localparam logic [1:0] RSEL_C = 2'd2;

	typedef struct packed {
		logic       clr_en;
		logic       in_latch;
		logic       load_commit;
		logic       fetch_rd;
		logic [2:0] fidx;
		logic       byte_cap;
		logic [2:0] cap_idx;
		logic       rf_rd;
		logic [1:0] rf_sel;
		logic       ra_cap;
		logic       rb_cap;
		logic       exec;
		logic       lda_cap;
		logic       div_step;
		logic       div_fin;
		logic       commit;
	} rcse_cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic [3:0] op;
		logic       rc_zero;
	} rcse_stat_t;

endpackage
`default_nettype wire

// ----- design/rcse_ctrl.sv -----
// Controller state machine: clear, load, fetch, read, execute, lda, divide, commit.
`default_nettype none
module rcse_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire               cmd,
	input  rcse_pkg::rcse_stat_t stat,
	output rcse_pkg::rcse_cmd_t  ctl,
	output logic              busy,
	output logic              done
);
	import rcse_pkg::*;

	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_LOAD   = 4'd2;
	localparam logic [3:0] S_FETCH  = 4'd3;
	localparam logic [3:0] S_RDA    = 4'd4;
	localparam logic [3:0] S_RDB    = 4'd5;
	localparam logic [3:0] S_RDC    = 4'd6;
	localparam logic [3:0] S_EXEC   = 4'd7;
	localparam logic [3:0] S_LDA    = 4'd8;
	localparam logic [3:0] S_DIV    = 4'd9;
	localparam logic [3:0] S_DIVF   = 4'd10;
	localparam logic [3:0] S_COMMIT = 4'd11;

	logic [3:0] state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       done_d;

	assign busy = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		done_d  = 1'b0;
		ctl     = '0;
		case (state_q)
			S_CLR: begin
				ctl.clr_en = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					ctl.in_latch = 1'b1;
					cnt_d = '0;
					state_d = cmd ? S_FETCH : S_LOAD;
				end
			end
			S_LOAD: begin
				ctl.load_commit = 1'b1;
				done_d = 1'b1;
				state_d = S_IDLE;
			end
			S_FETCH: begin
				ctl.fetch_rd = 1'b1;
				ctl.fidx = cnt_q[2:0];
				if (cnt_q != '0) begin
					ctl.byte_cap = 1'b1;
					ctl.cap_idx = cnt_q[2:0] - 3'd1;
				end
				if (cnt_q == 5'd5) begin
					state_d = S_RDA;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_RDA: begin
				ctl.byte_cap = 1'b1;
				ctl.cap_idx = 3'd5;
				ctl.rf_rd = 1'b1;
				ctl.rf_sel = RSEL_A;
				state_d = S_RDB;
			end
			S_RDB: begin
				ctl.ra_cap = 1'b1;
				ctl.rf_rd = 1'b1;
				ctl.rf_sel = RSEL_B;
				state_d = S_RDC;
			end
			S_RDC: begin
				ctl.rb_cap = 1'b1;
				ctl.rf_rd = 1'b1;
				ctl.rf_sel = RSEL_C;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				cnt_d = '0;
				if (stat.op == OP_LDA) begin
					state_d = S_LDA;
				end else if ((stat.op == OP_DIV || stat.op == OP_MOD) && !stat.rc_zero) begin
					state_d = S_DIV;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_LDA: begin
				ctl.lda_cap = 1'b1;
				state_d = S_COMMIT;
			end
			S_DIV: begin
				ctl.div_step = 1'b1;
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					state_d = S_DIVF;
				end
			end
			S_DIVF: begin
				ctl.div_fin = 1'b1;
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				ctl.commit = 1'b1;
				done_d = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done    <= done_d;
		end
	end

endmodule
`default_nettype wire

// ----- design/rcse_dp.sv -----
// Datapath: byte memory, register file, ALU, iterative divider and result registers.
`default_nettype none
module rcse_dp #(
	parameter int ADDR_BITS = rcse_pkg::ADDR_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  rcse_pkg::rcse_cmd_t ctl,
	output rcse_pkg::rcse_stat_t stat,
	input  wire  [15:0]         load_addr,
	input  wire  [7:0]          load_byte,
	output logic [15:0]         pc_before,
	output logic [3:0]          opcode,
	output logic                reg_written,
	output logic [3:0]          reg_index,
	output logic signed [31:0]  reg_value,
	output logic                mem_written,
	output logic [15:0]         mem_addr,
	output logic [7:0]          mem_byte,
	output logic                branch_taken,
	output logic [15:0]         pc_after,
	output logic                div_by_zero,
	output logic                bad_opcode
);
	import rcse_pkg::*;

	localparam int DEPTH = 1 << ADDR_BITS;

	logic [7:0]           mem [DEPTH];
	logic [7:0]           rdata_q;
	logic [ADDR_BITS-1:0] clr_q;
	logic [ADDR_BITS-1:0] pc_q;
	logic [ADDR_BITS-1:0] ld_addr_q;
	logic [7:0]           ld_byte_q;
	logic [7:0]           b_q [6];
	logic [31:0]          rf [16];
	logic [15:0]          rf_vld_q;
	logic [31:0]          rd_q;
	logic [31:0]          ra_q, rb_q, val_q;
	logic                 dz_q;
	logic [31:0]          rem_q, quo_q, dvs_q;
	logic                 qneg_q, rneg_q;

	logic [3:0]           op, a_idx, b_idx, c_idx, rf_addr;
	logic [31:0]          imm, rc;
	logic [ADDR_BITS-1:0] raddr;
	logic                 taken;
	logic                 rw;
	logic [ADDR_BITS-1:0] pc_next;
	logic [32:0]          dtrial;
	logic [31:0]          rem_sh;

	assign op    = b_q[0][7:4];
	assign a_idx = b_q[0][3:0];
	assign b_idx = b_q[1][7:4];
	assign c_idx = b_q[1][3:0];
	assign imm   = {b_q[2], b_q[3], b_q[4], b_q[5]};
	assign rc    = rd_q;

	assign stat.clr_last = &clr_q;
	assign stat.op       = op;
	assign stat.rc_zero  = (rd_q == '0);

	// memory read address: instruction fetch or load through register
	assign raddr = ctl.exec ? rb_q[ADDR_BITS-1:0] : pc_q + ADDR_BITS'(ctl.fidx);

	// memory write port and registered read
	always_ff @(posedge clk) begin
		if (ctl.clr_en) begin
			mem[clr_q] <= 8'd0;
		end else if (ctl.load_commit) begin
			mem[ld_addr_q] <= ld_byte_q;
		end else if (ctl.commit && op == OP_STO) begin
			mem[ra_q[ADDR_BITS-1:0]] <= rb_q[7:0];
		end
		if (ctl.fetch_rd || ctl.exec) begin
			rdata_q <= mem[raddr];
		end
	end

	// advance clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clr_en) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// register file read select
	always_comb begin
		case (ctl.rf_sel)
			RSEL_A:  rf_addr = a_idx;
			RSEL_B:  rf_addr = b_idx;
			default: rf_addr = c_idx;
		endcase
	end

	assign rw = (op != OP_JMP) && (op != OP_STO) && (op != OP_BAD);

	// register file storage and registered read
	always_ff @(posedge clk) begin
		if (ctl.commit && rw) begin
			rf[a_idx] <= val_q;
		end
		if (ctl.rf_rd) begin
			rd_q <= rf_vld_q[rf_addr] ? rf[rf_addr] : 32'd0;
		end
	end

	// track written registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (ctl.commit && rw) begin
			rf_vld_q[a_idx] <= 1'b1;
		end
	end

	// hold program counter
	assign taken = (a_idx == b_idx) || ($signed(ra_q) < $signed(rb_q));

	always_comb begin
		case (op)
			OP_JMP:  pc_next = taken ? imm[ADDR_BITS-1:0] : pc_q + ADDR_BITS'(6);
			OP_MOVI: pc_next = pc_q + ADDR_BITS'(6);
			OP_BAD:  pc_next = pc_q;
			default: pc_next = pc_q + ADDR_BITS'(2);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (ctl.commit) begin
			pc_q <= pc_next;
		end
	end

	// divider trial subtraction
	assign rem_sh = {rem_q[30:0], quo_q[31]};
	assign dtrial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	// latch request, bytes, operands; execute; divide
	always_ff @(posedge clk) begin
		if (ctl.in_latch) begin
			ld_addr_q <= load_addr[ADDR_BITS-1:0];
			ld_byte_q <= load_byte;
		end
		if (ctl.byte_cap) begin
			b_q[ctl.cap_idx] <= rdata_q;
		end
		if (ctl.ra_cap) begin
			ra_q <= rd_q;
		end
		if (ctl.rb_cap) begin
			rb_q <= rd_q;
		end
		if (ctl.exec) begin
			dz_q   <= (rc == '0);
			rem_q  <= '0;
			quo_q  <= rb_q[31] ? -rb_q : rb_q;
			dvs_q  <= rc[31] ? -rc : rc;
			qneg_q <= rb_q[31] ^ rc[31];
			rneg_q <= rb_q[31];
			case (op)
				OP_MOVI: val_q <= imm;
				OP_MOV:  val_q <= rb_q;
				OP_SHL:  val_q <= (rc >= 32'd32) ? 32'd0 : rb_q << rc[4:0];
				OP_SHR:  val_q <= (rc >= 32'd32) ? {32{rb_q[31]}}
				                 : 32'($signed(rb_q) >>> rc[4:0]);
				OP_NOT:  val_q <= ~rb_q;
				OP_AND:  val_q <= rb_q & rc;
				OP_OR:   val_q <= rb_q | rc;
				OP_XOR:  val_q <= rb_q ^ rc;
				OP_ADD:  val_q <= rb_q + rc;
				OP_MUL:  val_q <= 32'(rb_q * rc);
				OP_DIV:  val_q <= 32'hFFFF_FFFF;
				OP_MOD:  val_q <= rb_q;
				default: val_q <= 32'd0;
			endcase
		end
		if (ctl.lda_cap) begin
			val_q <= {24'd0, rdata_q};
		end
		if (ctl.div_step) begin
			if (!dtrial[32]) begin
				rem_q <= dtrial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (ctl.div_fin) begin
			if (op == OP_DIV) begin
				val_q <= qneg_q ? -quo_q : quo_q;
			end else begin
				val_q <= rneg_q ? -rem_q : rem_q;
			end
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (ctl.load_commit) begin
			pc_before    <= '0;
			opcode       <= '0;
			reg_written  <= 1'b0;
			reg_index    <= '0;
			reg_value    <= '0;
			mem_written  <= 1'b1;
			mem_addr     <= 16'(ld_addr_q);
			mem_byte     <= ld_byte_q;
			branch_taken <= 1'b0;
			pc_after     <= 16'(pc_q);
			div_by_zero  <= 1'b0;
			bad_opcode   <= 1'b0;
		end else if (ctl.commit) begin
			pc_before    <= 16'(pc_q);
			opcode       <= op;
			reg_written  <= rw;
			reg_index    <= rw ? a_idx : 4'd0;
			reg_value    <= rw ? val_q : 32'd0;
			mem_written  <= (op == OP_STO);
			mem_addr     <= (op == OP_STO) ? 16'(ra_q[ADDR_BITS-1:0]) : 16'd0;
			mem_byte     <= (op == OP_STO) ? rb_q[7:0] : 8'd0;
			branch_taken <= (op == OP_JMP) && taken;
			pc_after     <= 16'(pc_next);
			div_by_zero  <= (op == OP_DIV || op == OP_MOD) && dz_q;
			bad_opcode   <= (op == OP_BAD);
		end
	end

endmodule
`default_nettype wire

// ----- design/register_cpu_step_executor.sv -----
// Top level of the register CPU step executor.
//
// Usage: drive cmd/load_addr/load_byte and raise start; a request is taken
// at a rising edge where start is high and busy is low. cmd=0 writes one
// byte to memory, cmd=1 fetches and executes one instruction at pc.
// Each request gives one result, shown for exactly one cycle with done high.
// The receiver cannot stall; results are never held back.
// Steps: a memory write has one load step after acceptance. An instruction
// takes six single-port byte fetches, three register file reads, execute
// and commit; lda adds a step for its memory read; div and mod with a
// nonzero divisor add the steps of the one-bit-per-cycle divider and a final step.
// A new request can be taken in the cycle that done is high.
// After reset, busy stays high while a clearing pass zeroes the byte
// memory one entry per cycle; registers and pc reset to zero at once.
`default_nettype none
module register_cpu_step_executor #(
	parameter int ADDR_BITS = rcse_pkg::ADDR_BITS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	output logic               done,
	input  wire                cmd,
	input  wire  [15:0]        load_addr,
	input  wire  [7:0]         load_byte,
	output logic [15:0]        pc_before,
	output logic [3:0]         opcode,
	output logic               reg_written,
	output logic [3:0]         reg_index,
	output logic signed [31:0] reg_value,
	output logic               mem_written,
	output logic [15:0]        mem_addr,
	output logic [7:0]         mem_byte,
	output logic               branch_taken,
	output logic [15:0]        pc_after,
	output logic               div_by_zero,
	output logic               bad_opcode
);
	import rcse_pkg::*;

	rcse_cmd_t  ctl;
	rcse_stat_t stat;

	rcse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	rcse_dp #(.ADDR_BITS(ADDR_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.load_addr    (load_addr),
		.load_byte    (load_byte),
		.pc_before    (pc_before),
		.opcode       (opcode),
		.reg_written  (reg_written),
		.reg_index    (reg_index),
		.reg_value    (reg_value),
		.mem_written  (mem_written),
		.mem_addr     (mem_addr),
		.mem_byte     (mem_byte),
		.branch_taken (branch_taken),
		.pc_after     (pc_after),
		.div_by_zero  (div_by_zero),
		.bad_opcode   (bad_opcode)
	);

endmodule
`default_nettype wire
